/* src/dq_pkg.sv */
// Shared types, sizes and ring-pointer helpers for the double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 64;

    localparam int FIELD_W = 64;
    localparam int OCC_W   = 5;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [FIELD_W-1:0] push_word;
    } req_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_word;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } rsp_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } dq_cmd_t;

    // Fold a sum of two ring positions (below twice the depth) back into the ring.
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
        logic [PTR_W-1:0] res;
        if (sum >= SUM_W'(DEPTH))
        begin
            res = PTR_W'(sum - SUM_W'(DEPTH));
        end
        else
        begin
            res = PTR_W'(sum);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/double_ended_queue_unit.sv */
// Double-ended queue top level: controller plus datapath over a ring store.
// A request is latched in IDLE, the store is accessed in ACCESS and the result is offered in RESP.
// A new request is taken only once the result has been taken; the single
// store port with its registered read sets the access step in between.
// Reset clears the front pointer and the count; stored words are not cleared.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
`default_nettype none

module double_ended_queue_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire dq_pkg::req_item_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output dq_pkg::rsp_item_t      rsp
);

    dq_pkg::dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    dq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != dq_pkg::STATUS_OK) |-> (rsp.popped_word == '0))
        else $error("flagged result carries a nonzero word");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == dq_pkg::STATUS_FULL)
            |-> (rsp.occupancy == dq_pkg::OCC_W'(dq_pkg::DEPTH)))
        else $error("full status without a full queue");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !rsp_valid)
        else $error("request taken while a result is pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> ##2 rsp_valid)
        else $error("result not offered two cycles after transfer");

endmodule

`default_nettype wire

/* src/dq_ram.sv */
// Generic single-port RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

/* src/dq_ctrl.sv */
// Controller for the double-ended queue: accept, access the store, offer the result.
// Depends on dq_pkg for the command struct.
`default_nettype none

module dq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output dq_pkg::dq_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ACCESS = 3'b010,
        ST_RESP   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);
    assign cmd.load  = (state_reg == ST_IDLE) && req_valid;
    assign cmd.exec  = (state_reg == ST_ACCESS);

endmodule

`default_nettype wire

/* src/dq_datapath.sv */
// Datapath of the double-ended queue: item latch, ring pointers, store and result.
// Depends on dq_pkg and dq_ram.
`default_nettype none

module dq_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dq_pkg::dq_cmd_t   cmd,
    input  wire dq_pkg::req_item_t req,
    output dq_pkg::rsp_item_t      rsp
);

    dq_pkg::op_t                     op_reg;
    logic [dq_pkg::WORD_WIDTH-1:0]   word_reg;
    logic [dq_pkg::PTR_W-1:0]        front_reg;
    logic [dq_pkg::PTR_W-1:0]        front_next;
    logic [dq_pkg::CNT_W-1:0]        count_reg;
    logic [dq_pkg::CNT_W-1:0]        count_next;
    dq_pkg::status_t                 status_reg;
    dq_pkg::status_t                 status_next;
    logic                            pop_ok_reg;
    logic                            pop_ok_next;

    logic                            ram_we;
    logic                            ram_re;
    logic [dq_pkg::PTR_W-1:0]        ram_addr;
    logic [dq_pkg::WORD_WIDTH-1:0]   ram_rd_data;

    logic [dq_pkg::SUM_W-1:0]        tail_sum;
    logic [dq_pkg::PTR_W-1:0]        front_inc;
    logic [dq_pkg::PTR_W-1:0]        front_dec;
    logic                            is_full;
    logic                            is_empty;

    assign tail_sum  = dq_pkg::SUM_W'(front_reg) + dq_pkg::SUM_W'(count_reg);
    assign front_inc = (front_reg == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0
                     : front_reg + dq_pkg::PTR_W'(1);
    assign front_dec = (front_reg == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                     : front_reg - dq_pkg::PTR_W'(1);
    assign is_full   = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = dq_pkg::STATUS_OK;
        pop_ok_next = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = front_reg;
        if (cmd.exec)
        begin
            unique case (op_reg)
                dq_pkg::OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_addr   = dq_pkg::ring_wrap(tail_sum);
                        count_next = count_reg + dq_pkg::CNT_W'(1);
                    end
                end
                dq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_addr   = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + dq_pkg::CNT_W'(1);
                    end
                end
                dq_pkg::OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        pop_ok_next = 1'b1;
                        ram_addr    = dq_pkg::ring_wrap(tail_sum - dq_pkg::SUM_W'(1));
                        count_next  = count_reg - dq_pkg::CNT_W'(1);
                    end
                end
                dq_pkg::OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        pop_ok_next = 1'b1;
                        ram_addr    = front_reg;
                        front_next  = front_inc;
                        count_next  = count_reg - dq_pkg::CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Item and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.operation;
            word_reg <= dq_pkg::WORD_WIDTH'(req.push_word);
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::WORD_WIDTH),
        .DEPTH (dq_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .rd_en   (ram_re),
        .addr    (ram_addr),
        .wr_data (word_reg),
        .rd_data (ram_rd_data)
    );

    // Read data holds until the next pop, so it stays put during a stall
    assign rsp.popped_word = pop_ok_reg ? dq_pkg::FIELD_W'(ram_rd_data) : '0;
    assign rsp.status      = status_reg;
    assign rsp.occupancy   = dq_pkg::OCC_W'(count_reg);

endmodule

`default_nettype wire

/* bench/tb_double_ended_queue_unit.sv */
// Self-checking bench for the double-ended queue unit: random and directed deque operations
// against an in-bench ring model, with random idling of requests and back-pressure on results.
// Depends on dq_pkg and double_ended_queue_unit.

module tb_double_ended_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_OPS    = 1727;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        req_item_t   item;
        int unsigned gap;
        bit          drain;
    } stim_op_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    stim_op_t  pending_ops[$];
    rsp_item_t due_results[$];

    // Ring model of the deque
    logic [WORD_WIDTH-1:0] ring_words [DEPTH];
    logic [PTR_W-1:0]      head_slot    = '0;
    int unsigned           stored_count = 0;

    bit          req_fired   = 1'b0;
    bit          rsp_fired   = 1'b0;
    bit          gap_armed   = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned rsp_count   = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    double_ended_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    function automatic rsp_item_t deque_apply(input req_item_t item);
        rsp_item_t        res;
        logic [PTR_W-1:0] slot;
        res.popped_word = '0;
        res.status      = STATUS_OK;
        case (item.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (stored_count >= DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else if (item.operation == OP_PUSH_BACK)
                begin
                    slot = PTR_W'((head_slot + stored_count) % DEPTH);
                    ring_words[slot] = item.push_word[WORD_WIDTH-1:0];
                    stored_count++;
                end
                else
                begin
                    head_slot = PTR_W'((head_slot + DEPTH - 1) % DEPTH);
                    ring_words[head_slot] = item.push_word[WORD_WIDTH-1:0];
                    stored_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (stored_count == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else if (item.operation == OP_POP_BACK)
                begin
                    slot = PTR_W'((head_slot + stored_count - 1) % DEPTH);
                    res.popped_word = FIELD_W'(ring_words[slot]);
                    stored_count--;
                end
                else
                begin
                    res.popped_word = FIELD_W'(ring_words[head_slot]);
                    head_slot = PTR_W'((head_slot + 1) % DEPTH);
                    stored_count--;
                end
            end
        endcase
        res.occupancy = OCC_W'(stored_count);
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_word();
        logic [FIELD_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic void add_op(input op_t op, input logic [FIELD_W-1:0] word,
                                   input int unsigned gap, input bit drain);
        stim_op_t s;
        s.item.operation = op;
        s.item.push_word = word;
        s.gap            = gap;
        s.drain          = drain;
        pending_ops.push_back(s);
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin : cycle_guard
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Sample both channels; check results before recording the new request
    always @(posedge clk)
    begin : watch_ports
        rsp_item_t want;
        req_fired = 1'b0;
        rsp_fired = 1'b0;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_fired = 1'b1;
                if (due_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected result: word %h status %0d occupancy %0d",
                                 rsp.popped_word, rsp.status, rsp.occupancy);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.popped_word !== want.popped_word || rsp.status !== want.status ||
                        rsp.occupancy !== want.occupancy)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("mismatch: expected word %h status %0d occupancy %0d, %s",
                                     want.popped_word, want.status, want.occupancy,
                                     $sformatf("got word %h status %0d occupancy %0d",
                                               rsp.popped_word, rsp.status, rsp.occupancy));
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                req_fired = 1'b1;
                due_results.push_back(deque_apply(req));
            end
        end
    end

    always @(negedge clk)
    begin : drive_req
        logic     next_valid;
        stim_op_t cur;
        next_valid = req_valid && !req_fired;
        if (rst_n && !next_valid && pending_ops.size() > 0)
        begin
            if (!gap_armed)
            begin
                gap_left  = pending_ops[0].gap;
                gap_armed = 1'b1;
            end
            if (gap_left > 0)
            begin
                gap_left--;
            end
            // hold a marked operation until every outstanding result has come back
            else if (!(pending_ops[0].drain && due_results.size() > 0))
            begin
                cur        = pending_ops.pop_front();
                req       <= cur.item;
                next_valid = 1'b1;
                gap_armed  = 1'b0;
            end
        end
        req_valid <= next_valid;
    end

    always @(negedge clk)
    begin : drive_rsp_stall
        if (rst_n)
        begin
            if (rsp_fired)
            begin
                rsp_count++;
                if (rsp_count % 600 == 300)
                    stall_left = LONG_HOLD;
                else if ((rsp_count / 100) % 3 == 0)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 7);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : run_ctrl
        bit          fill_bias;
        bit          no_gaps;
        op_t         op;
        int unsigned gap;

        // Empty pops, fill to the brim from both ends, overflow, then pops
        add_op(OP_POP_BACK, '1, 0, 1'b0);
        add_op(OP_POP_FRONT, '1, 0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0:       add_op(OP_PUSH_BACK, '0, 0, 1'b0);
                1:       add_op(OP_PUSH_FRONT, '1, $urandom_range(0, 7), 1'b0);
                2:       add_op(OP_PUSH_BACK, {$urandom, $urandom}, 0, 1'b0);
                default: add_op(OP_PUSH_FRONT, FIELD_W'(1) << (i * 4), 0, 1'b0);
            endcase
        end
        add_op(OP_PUSH_BACK, '1, 0, 1'b0);
        add_op(OP_PUSH_FRONT, '0, 0, 1'b0);
        add_op(OP_POP_FRONT, '0, 0, 1'b0);
        add_op(OP_POP_BACK, '0, 2, 1'b0);
        add_op(OP_POP_FRONT, '1, 0, 1'b0);

        // Pick fill-leaning or drain-leaning runs at random so both full and empty recur
        fill_bias = 1'b1;
        no_gaps   = 1'b0;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
                fill_bias = 1'($urandom_range(0, 1));
            if (i % 150 == 0)
                no_gaps = ~no_gaps;
            if (($urandom_range(0, 99) < 75) == fill_bias)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            add_op(op, pick_word(), gap, i == 400 || i == 1100);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_valid)
            @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
